### sv/cdup_pkg.sv
`timescale 1ns / 1ps

package cdup_pkg;

   localparam int BYTE_W       = 8;
   localparam int VALUE_W      = 32;
   localparam int KIND_W       = 3;
   localparam int LEB_COUNT_W  = 3;
   localparam int SLOT_W       = 2;
   localparam int SECTION_W    = 2;
   localparam int NUM_SECTIONS = 4;

   // Fifth LEB128 byte always closes the value.
   localparam logic [LEB_COUNT_W-1:0] LEB_LAST_COUNT = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [KIND_W-1:0] KIND_STATIC_FIELD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSTANCE_FIELD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DIRECT_METHOD  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_VIRTUAL_METHOD = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY          = 3'd4;

   localparam logic [SLOT_W-1:0] SLOT_DELTA = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_FLAGS = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_CODE  = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_MEMBERS = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   // One decoded LEB128 value handed from the front to the back.
   typedef struct packed {
      logic               first;
      logic [VALUE_W-1:0] value;
   } value_entry_type;

   // One result record produced by the back.
   typedef struct packed {
      logic [KIND_W-1:0]  record_kind;
      logic [VALUE_W-1:0] member_index;
      logic [VALUE_W-1:0] access_bits;
      logic [VALUE_W-1:0] code_offset;
      logic               last_of_class;
   } record_type;

endpackage

### sv/cdup_front.sv
`timescale 1ns / 1ps

module cdup_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cdup_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                            req_start_of_item,
   input  logic                            queue_full,
   output logic                            push_valid,
   output cdup_pkg::value_entry_type       push_entry
);

   logic                                 started_ff, started_in;
   logic                                 first_pend_ff, first_pend_in;
   logic [cdup_pkg::LEB_COUNT_W-1:0]     count_ff, count_in;
   logic [cdup_pkg::VALUE_W-1:0]         value_ff, value_in;

   logic                                 accept;
   logic                                 active;
   logic [cdup_pkg::LEB_COUNT_W-1:0]     count_eff;
   logic [cdup_pkg::VALUE_W-1:0]         value_eff;
   logic [cdup_pkg::VALUE_W-1:0]         shifted;
   logic [cdup_pkg::VALUE_W-1:0]         assembled;
   logic                                 value_done;
   logic                                 first_eff;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign active    = started_ff || req_start_of_item;

   assign count_eff = req_start_of_item ? '0 : count_ff;
   assign value_eff = req_start_of_item ? '0 : value_ff;
   assign first_eff = req_start_of_item || first_pend_ff;

   // Place the seven payload bits; the fifth byte gives only its low nibble.
   always_comb begin
      case (count_eff)
         3'd0:    shifted = {25'd0, req_data_byte[6:0]};
         3'd1:    shifted = {18'd0, req_data_byte[6:0], 7'd0};
         3'd2:    shifted = {11'd0, req_data_byte[6:0], 14'd0};
         3'd3:    shifted = {4'd0, req_data_byte[6:0], 21'd0};
         default: shifted = {req_data_byte[3:0], 28'd0};
      endcase
   end

   assign assembled  = value_eff | shifted;
   assign value_done = !req_data_byte[7] || (count_eff == cdup_pkg::LEB_LAST_COUNT);

   assign push_valid       = accept && active && value_done;
   assign push_entry.first = first_eff;
   assign push_entry.value = assembled;

   always_comb begin
      started_in    = started_ff;
      first_pend_in = first_pend_ff;
      count_in      = count_ff;
      value_in      = value_ff;
      if (accept && active) begin
         started_in = 1'b1;
         if (value_done) begin
            first_pend_in = 1'b0;
            count_in      = '0;
            value_in      = '0;
         end else begin
            first_pend_in = first_eff;
            count_in      = count_eff + 3'd1;
            value_in      = assembled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         first_pend_ff <= 1'b0;
         count_ff      <= '0;
         value_ff      <= '0;
      end else begin
         started_ff    <= started_in;
         first_pend_ff <= first_pend_in;
         count_ff      <= count_in;
         value_ff      <= value_in;
      end
   end

endmodule

### sv/cdup_queue.sv
`timescale 1ns / 1ps

module cdup_queue #(
   parameter int DEPTH = cdup_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  cdup_pkg::value_entry_type   push_entry,
   output logic                        full,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output cdup_pkg::value_entry_type   pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cdup_pkg::value_entry_type entries_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/cdup_back.sv
`timescale 1ns / 1ps

module cdup_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  cdup_pkg::value_entry_type   pop_entry,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output cdup_pkg::record_type        rsp_record
);

   localparam int NS = cdup_pkg::NUM_SECTIONS;

   cdup_pkg::phase_type                  phase_ff, phase_in;
   logic [cdup_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic [cdup_pkg::SECTION_W-1:0]       section_ff, section_in;
   logic [cdup_pkg::VALUE_W-1:0]         counts_ff [NS];
   logic [cdup_pkg::VALUE_W-1:0]         counts_in [NS];
   logic [NS-1:0]                        nz_ff, nz_in;
   logic [cdup_pkg::VALUE_W-1:0]         left_ff, left_in;
   logic [cdup_pkg::VALUE_W-1:0]         index_ff, index_in;
   logic [cdup_pkg::VALUE_W-1:0]         flags_ff, flags_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   cdup_pkg::record_type                 record_ff, record_in;

   logic                                 pop;
   logic                                 emit;
   logic [cdup_pkg::VALUE_W-1:0]         v;
   cdup_pkg::phase_type                  eff_phase;
   logic [cdup_pkg::SLOT_W-1:0]          eff_slot;
   logic [NS-1:0]                        hdr_mask;
   logic [NS-1:0]                        above_mask;
   logic [NS-1:0]                        pick_mask;
   logic                                 pick_found;
   logic [cdup_pkg::SECTION_W-1:0]       pick_idx;
   logic                                 is_method;

   assign pop_ready  = !rsp_valid_ff || rsp_ready;
   assign pop        = pop_valid && pop_ready;
   assign v          = pop_entry.value;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_record = record_ff;

   // A start mark restarts the header from its first value.
   assign eff_phase = pop_entry.first ? cdup_pkg::PH_HEADER : phase_ff;
   assign eff_slot  = pop_entry.first ? cdup_pkg::SLOT_DELTA : slot_ff;
   assign is_method = section_ff[1];

   assign hdr_mask   = {(v != '0), nz_ff[NS-2:0]};
   assign above_mask = nz_ff & (4'b1110 << section_ff);
   assign pick_mask  = (eff_phase == cdup_pkg::PH_HEADER) ? hdr_mask : above_mask;

   // Lowest nonempty section in the candidate mask.
   always_comb begin
      pick_found = 1'b1;
      if (pick_mask[0]) begin
         pick_idx = 2'd0;
      end else if (pick_mask[1]) begin
         pick_idx = 2'd1;
      end else if (pick_mask[2]) begin
         pick_idx = 2'd2;
      end else if (pick_mask[3]) begin
         pick_idx = 2'd3;
      end else begin
         pick_idx   = 2'd0;
         pick_found = 1'b0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      slot_in    = slot_ff;
      section_in = section_ff;
      counts_in  = counts_ff;
      nz_in      = nz_ff;
      left_in    = left_ff;
      index_in   = index_ff;
      flags_in   = flags_ff;
      record_in  = record_ff;
      emit       = 1'b0;
      if (pop) begin
         case (eff_phase)
            cdup_pkg::PH_HEADER: begin
               counts_in[eff_slot] = v;
               nz_in[eff_slot]     = (v != '0);
               if (eff_slot != cdup_pkg::SLOT_LAST) begin
                  phase_in = cdup_pkg::PH_HEADER;
                  slot_in  = eff_slot + 2'd1;
               end else if (!pick_found) begin
                  phase_in                = cdup_pkg::PH_DONE;
                  slot_in                 = cdup_pkg::SLOT_DELTA;
                  emit                    = 1'b1;
                  record_in.record_kind   = cdup_pkg::KIND_EMPTY;
                  record_in.member_index  = '0;
                  record_in.access_bits   = '0;
                  record_in.code_offset   = '0;
                  record_in.last_of_class = 1'b1;
               end else begin
                  phase_in   = cdup_pkg::PH_MEMBERS;
                  slot_in    = cdup_pkg::SLOT_DELTA;
                  section_in = pick_idx;
                  left_in    = (pick_idx == cdup_pkg::SLOT_LAST) ? v : counts_ff[pick_idx];
                  index_in   = '0;
               end
            end
            cdup_pkg::PH_MEMBERS: begin
               if (slot_ff == cdup_pkg::SLOT_DELTA) begin
                  index_in = index_ff + v;
                  slot_in  = cdup_pkg::SLOT_FLAGS;
               end else if (slot_ff == cdup_pkg::SLOT_FLAGS && is_method) begin
                  flags_in = v;
                  slot_in  = cdup_pkg::SLOT_CODE;
               end else begin
                  emit                    = 1'b1;
                  record_in.record_kind   = {1'b0, section_ff};
                  record_in.member_index  = index_ff;
                  record_in.access_bits   = is_method ? flags_ff : v;
                  record_in.code_offset   = is_method ? v : '0;
                  record_in.last_of_class = 1'b0;
                  left_in                 = left_ff - 32'd1;
                  slot_in                 = cdup_pkg::SLOT_DELTA;
                  if (left_ff == 32'd1) begin
                     if (!pick_found) begin
                        record_in.last_of_class = 1'b1;
                        phase_in                = cdup_pkg::PH_DONE;
                     end else begin
                        section_in = pick_idx;
                        left_in    = counts_ff[pick_idx];
                        index_in   = '0;
                     end
                  end
               end
            end
            default: begin
               // Idle or complete: drop the value.
            end
         endcase
      end
      rsp_valid_in = pop ? emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cdup_pkg::PH_IDLE;
         slot_ff      <= '0;
         section_ff   <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         section_ff   <= section_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      counts_ff <= counts_in;
      left_ff   <= left_in;
      index_ff  <= index_in;
      flags_ff  <= flags_in;
      record_ff <= record_in;
   end

endmodule

### sv/class_data_uleb128_parser_unit.sv
`timescale 1ns / 1ps
// Path: a byte that completes a member (or an all-zero header) is registered in the
//   value queue, then its result is registered in the back's output register.
// Throughput: one byte per cycle while the value queue is not full; the two-entry value
//   queue and the output register let the byte and result sides stall independently.
// Reset (synchronous, active high): parser idle, queue empty, no result pending;
//   bytes are ignored until one arrives with start_of_item set.
module class_data_uleb128_parser_unit #(
   parameter int QUEUE_DEPTH = cdup_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdup_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_start_of_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cdup_pkg::KIND_W-1:0]       rsp_record_kind,
   output logic [cdup_pkg::VALUE_W-1:0]      rsp_member_index,
   output logic [cdup_pkg::VALUE_W-1:0]      rsp_access_bits,
   output logic [cdup_pkg::VALUE_W-1:0]      rsp_code_offset,
   output logic                              rsp_last_of_class
);

   // Front: LEB128 assembly, one byte per request. A request either extends
   // the value in flight or completes it; completed values are pushed to the
   // queue tagged with whether they open a new item.
   logic                        push_valid;
   cdup_pkg::value_entry_type   push_entry;
   logic                        queue_full;

   // Queue: short FIFO of complete values between front and back.
   logic                        pop_valid;
   logic                        pop_ready;
   cdup_pkg::value_entry_type   pop_entry;

   // Back: header/section walk, one value per cycle unless an untaken result holds the output register.
   cdup_pkg::record_type        record;

   cdup_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_start_of_item (req_start_of_item),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_entry        (push_entry)
   );

   cdup_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   cdup_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_record (record)
   );

   // Unpack the result register onto the response ports.
   assign rsp_record_kind   = record.record_kind;
   assign rsp_member_index  = record.member_index;
   assign rsp_access_bits   = record.access_bits;
   assign rsp_code_offset   = record.code_offset;
   assign rsp_last_of_class = record.last_of_class;

   // The empty-class record is always the final one and carries zeros.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == cdup_pkg::KIND_EMPTY)
      |-> rsp_last_of_class && (rsp_member_index == '0) && (rsp_access_bits == '0))
      else $error("empty-class record malformed");

   // Field records never carry a code offset.
   a_field_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_record_kind == cdup_pkg::KIND_STATIC_FIELD) ||
                    (rsp_record_kind == cdup_pkg::KIND_INSTANCE_FIELD))
      |-> (rsp_code_offset == '0))
      else $error("field record with nonzero code offset");

   // Coming out of reset the queue is empty, so requests are taken at once.
   a_ready_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready)
      else $error("not ready after reset");

endmodule
